// File: src/qead_pkg.sv
// qead_pkg: shared types, register codes and constants for the quadrature
// encoder decoder with speed-dependent step size
// no dependencies; every other file of the block but qead_stream_if uses it
`default_nettype none

package qead_pkg;

  // width of the configuration address and of the data bus
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // step clamp limits
  localparam logic [7:0] StepMin = 8'd1;
  localparam logic [7:0] StepMax = 8'd150;

  // register reset values
  localparam logic [7:0]  LargeStepRst     = 8'd100;
  localparam logic [7:0]  MediumStepRst    = 8'd10;
  localparam logic [7:0]  SmallStepRst     = 8'd1;
  localparam logic [15:0] FastThresholdRst = 16'd80;
  localparam logic [15:0] SlowThresholdRst = 16'd180;

  // register index codes (byte address / 4)
  typedef enum logic [2:0] {
    REG_LARGE_STEP     = 3'd0,
    REG_MEDIUM_STEP    = 3'd1,
    REG_SMALL_STEP     = 3'd2,
    REG_FAST_THRESHOLD = 3'd3,
    REG_SLOW_THRESHOLD = 3'd4
  } reg_idx_e;

  // item kind
  typedef enum logic {
    MODE_PIN  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  // result move code
  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_INC  = 2'd1,
    MOVE_DEC  = 2'd2
  } move_e;

  // input item payload
  typedef struct packed {
    logic mode;
    logic phase_a;
    logic phase_b;
    logic button;
  } in_item_t;

  // result item payload
  typedef struct packed {
    move_e      move;
    logic [7:0] step;
    logic       reset_request;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]  large_step;
    logic [7:0]  medium_step;
    logic [7:0]  small_step;
    logic [15:0] fast_threshold;
    logic [15:0] slow_threshold;
  } cfg_t;

  // next gray code for a clockwise transition
  function automatic logic [1:0] next_cw(input logic [1:0] code);
    logic [1:0] n;
    case (code)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd3;
      2'd2:    n = 2'd0;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  // next gray code for a counter-clockwise transition
  function automatic logic [1:0] next_ccw(input logic [1:0] code);
    logic [1:0] n;
    case (code)
      2'd0:    n = 2'd2;
      2'd1:    n = 2'd0;
      2'd2:    n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  // clamp a step register to the legal range
  function automatic logic [7:0] clamp_step(input logic [7:0] s);
    logic [7:0] r;
    if (s < StepMin) begin
      r = StepMin;
    end else if (s > StepMax) begin
      r = StepMax;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/qead_stream_if.sv
// qead_stream_if: valid/ready channel carrying one payload per transfer
// payload type is set per instance; used with qead_pkg item types
`default_nettype none

interface qead_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/qead_apb_regs.sv
// qead_apb_regs: apb-style configuration register file
// depends on qead_pkg for register codes, reset values and cfg_t
`default_nettype none

module qead_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qead_pkg::AddrW-1:0]  paddr,
  input  wire logic [qead_pkg::DataW-1:0]  pwdata,
  output logic      [qead_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output qead_pkg::cfg_t                   cfg_o
);

  qead_pkg::cfg_t     cfg_q;
  qead_pkg::reg_idx_e idx;
  logic               wr_en;
  logic               addr_hi;

  assign idx     = qead_pkg::reg_idx_e'(paddr[4:2]);
  assign addr_hi = 1'b0;
  assign wr_en   = psel & penable & pwrite & ~addr_hi;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.large_step     <= qead_pkg::LargeStepRst;
      cfg_q.medium_step    <= qead_pkg::MediumStepRst;
      cfg_q.small_step     <= qead_pkg::SmallStepRst;
      cfg_q.fast_threshold <= qead_pkg::FastThresholdRst;
      cfg_q.slow_threshold <= qead_pkg::SlowThresholdRst;
    end else if (wr_en) begin
      case (idx)
        qead_pkg::REG_LARGE_STEP:     cfg_q.large_step     <= pwdata[7:0];
        qead_pkg::REG_MEDIUM_STEP:    cfg_q.medium_step    <= pwdata[7:0];
        qead_pkg::REG_SMALL_STEP:     cfg_q.small_step     <= pwdata[7:0];
        qead_pkg::REG_FAST_THRESHOLD: cfg_q.fast_threshold <= pwdata[15:0];
        qead_pkg::REG_SLOW_THRESHOLD: cfg_q.slow_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    unique case (idx)
      qead_pkg::REG_LARGE_STEP:     prdata = qead_pkg::DataW'(cfg_q.large_step);
      qead_pkg::REG_MEDIUM_STEP:    prdata = qead_pkg::DataW'(cfg_q.medium_step);
      qead_pkg::REG_SMALL_STEP:     prdata = qead_pkg::DataW'(cfg_q.small_step);
      qead_pkg::REG_FAST_THRESHOLD: prdata = qead_pkg::DataW'(cfg_q.fast_threshold);
      qead_pkg::REG_SLOW_THRESHOLD: prdata = qead_pkg::DataW'(cfg_q.slow_threshold);
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/qead_core.sv
// qead_core: input register, decoder state and per-item result logic
// depends on qead_pkg for item types, gray tables and step clamp
`default_nettype none

module qead_core #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  qead_pkg::cfg_t           cfg_i,
  input  wire logic                in_valid_i,
  input  qead_pkg::in_item_t       in_data_i,
  output logic                     in_ready_o,
  input  wire logic                adv_i,
  output logic                     res_valid_o,
  output qead_pkg::out_item_t      res_o
);

  localparam int unsigned CmpW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

  // input register
  logic                s1_valid_q;
  qead_pkg::in_item_t  s1_item_q;

  // decoder state
  logic [1:0]              prev_q, prev_d;
  logic [1:0]              cw_run_q, cw_run_d;
  logic [1:0]              ccw_run_q, ccw_run_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic                    switch_q, switch_d;

  logic [1:0]      code;
  logic [1:0]      cw_inc, ccw_inc;
  logic [CmpW-1:0] el_ext;
  logic [7:0]      step_sel;
  logic            upd;

  assign in_ready_o  = ~s1_valid_q | adv_i;
  assign res_valid_o = s1_valid_q;
  assign upd         = s1_valid_q & adv_i;

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // step choice from elapsed time against the two thresholds
  assign el_ext = CmpW'(elapsed_q);
  always_comb begin
    if (el_ext < CmpW'(cfg_i.fast_threshold)) begin
      step_sel = qead_pkg::clamp_step(cfg_i.large_step);
    end else if (el_ext < CmpW'(cfg_i.slow_threshold)) begin
      step_sel = qead_pkg::clamp_step(cfg_i.medium_step);
    end else begin
      step_sel = qead_pkg::clamp_step(cfg_i.small_step);
    end
  end

  assign code    = {s1_item_q.phase_b, s1_item_q.phase_a};
  assign cw_inc  = cw_run_q + 2'd1;
  assign ccw_inc = ccw_run_q + 2'd1;

  // next state and result for the item in the input register
  always_comb begin
    prev_d    = prev_q;
    cw_run_d  = cw_run_q;
    ccw_run_d = ccw_run_q;
    elapsed_d = elapsed_q;
    switch_d  = switch_q;
    res_o.move          = qead_pkg::MOVE_NONE;
    res_o.step          = '0;
    res_o.reset_request = 1'b0;
    if (s1_item_q.mode == qead_pkg::MODE_TICK) begin
      // saturating tick count
      if (elapsed_q != {ELAPSED_BITS{1'b1}}) begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end else begin
      // switch release
      res_o.reset_request = s1_item_q.button & ~switch_q;
      switch_d            = s1_item_q.button;
      prev_d              = code;
      if (qead_pkg::next_cw(prev_q) == code) begin
        cw_run_d  = cw_inc;
        ccw_run_d = 2'd0;
        if (cw_inc == 2'd0) begin
          res_o.move = qead_pkg::MOVE_DEC;
          res_o.step = step_sel;
          elapsed_d  = '0;
        end
      end else if (qead_pkg::next_ccw(prev_q) == code) begin
        ccw_run_d = ccw_inc;
        cw_run_d  = 2'd0;
        if (ccw_inc == 2'd0) begin
          res_o.move = qead_pkg::MOVE_INC;
          res_o.step = step_sel;
          elapsed_d  = '0;
        end
      end
    end
  end

  // state update when the item moves on to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 2'd0;
      cw_run_q  <= 2'd0;
      ccw_run_q <= 2'd0;
      elapsed_q <= '0;
      switch_q  <= 1'b1;
    end else if (upd) begin
      prev_q    <= prev_d;
      cw_run_q  <= cw_run_d;
      ccw_run_q <= ccw_run_d;
      elapsed_q <= elapsed_d;
      switch_q  <= switch_d;
    end
  end

endmodule

`default_nettype wire

// File: src/quadrature_encoder_accel_decoder.sv
// quadrature_encoder_accel_decoder: top level of the encoder decoder
// depends on qead_pkg, qead_stream_if, qead_apb_regs and qead_core
//
//   channel  direction  transfer when            payload
//   in_i     sink       in_i.valid & in_i.ready  mode, phase_a, phase_b, button
//   out_o    source     valid & out_o.ready      move, step, reset_request
//   apb      slave      psel & penable & pready  5 step/threshold registers
//
// every item yields one result, passing the input register and then the result register
// one item per cycle sustained while out_o.ready holds: input register -> decode logic -> result register
// a stalled result holds in the result register while one more item waits
// in the input register; the input stalls only once both are full
// rst_ni clears both valid flags, the decoder state and the registers at once
`default_nettype none

module quadrature_encoder_accel_decoder #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  qead_stream_if.sink                     in_i,
  qead_stream_if.source                   out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [qead_pkg::AddrW-1:0] paddr,
  input  wire logic [qead_pkg::DataW-1:0] pwdata,
  output logic      [qead_pkg::DataW-1:0] prdata,
  output logic                            pready
);

  qead_pkg::cfg_t      cfg;
  qead_pkg::out_item_t res;
  logic                res_valid;
  logic                adv;
  logic                out_valid_q;
  qead_pkg::out_item_t out_data_q;

  // configuration registers
  qead_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // decoder core
  qead_core #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .adv_i       (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register loads whenever it is empty or being drained
  assign adv = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

// File: src/qead_checker.sv
// qead_checker: port-level checks on the encoder decoder top level
// depends on qead_pkg; bound to quadrature_encoder_accel_decoder below
`default_nettype none

module qead_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input qead_pkg::out_item_t      out_data,
  input wire logic                pready
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a move always carries a step, no move carries none
  a_move_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((out_data.move == qead_pkg::MOVE_NONE) == (out_data.step == 8'd0)))
    else $error("move and step disagree");

  // step stays at or below the upper clamp limit
  a_step_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.step <= qead_pkg::StepMax))
    else $error("step above clamp limit");

  // configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind quadrature_encoder_accel_decoder qead_checker u_qead_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data),
  .pready    (pready)
);

`default_nettype wire

// File: tb/sv/qead_checker.sv
// qead_scoreboard: predicts every result of the encoder decoder and compares transfers
// depends on qead_pkg; watches the item channels and the register port of the block
module qead_scoreboard
  import qead_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic [DataW-1:0] prdata,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      moves_o,
  output int unsigned      releases_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // gray code successors, two bits per code with code 0 in the low bits
  localparam logic [7:0] CwSucc  = {2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [7:0] CcwSucc = {2'd1, 2'd3, 2'd0, 2'd2};

  // own copy of the decoder state and the register set
  logic [1:0]              last_code;
  logic [1:0]              cw_count;
  logic [1:0]              ccw_count;
  logic [ELAPSED_BITS-1:0] ticks;
  logic                    switch_up;
  cfg_t                    regs;

  out_item_t   predicted_results [$];
  int unsigned fails;
  int unsigned checks;
  int unsigned steps_seen;
  int unsigned releases_seen;

  // work out the result of one item and advance the state
  function automatic out_item_t decode_item(input in_item_t item);
    out_item_t  res;
    logic [1:0] code;
    logic [7:0] amount;
    res = '{move: MOVE_NONE, step: '0, reset_request: 1'b0};
    if (item.mode == MODE_TICK) begin
      // elapsed time sticks at its top value
      if (ticks != '1) begin
        ticks = ticks + 1'b1;
      end
    end else begin
      code = {item.phase_b, item.phase_a};
      // only a change towards up asks for a value reset
      if (item.button != switch_up) begin
        res.reset_request = item.button;
        switch_up = item.button;
      end
      // speed class: fast test first, then slow
      if (ticks < regs.fast_threshold) begin
        amount = regs.large_step;
      end else if (ticks < regs.slow_threshold) begin
        amount = regs.medium_step;
      end else begin
        amount = regs.small_step;
      end
      if (amount < StepMin) begin
        amount = StepMin;
      end else if (amount > StepMax) begin
        amount = StepMax;
      end
      // every fourth detent of a run moves the value
      if (CwSucc[2*last_code +: 2] == code) begin
        ccw_count = '0;
        cw_count = cw_count + 1'b1;
        if (cw_count == '0) begin
          res.move = MOVE_DEC;
          res.step = amount;
          ticks = '0;
        end
      end else if (CcwSucc[2*last_code +: 2] == code) begin
        cw_count = '0;
        ccw_count = ccw_count + 1'b1;
        if (ccw_count == '0) begin
          res.move = MOVE_INC;
          res.step = amount;
          ticks = '0;
        end
      end
      last_code = code;
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t        want;
    logic [DataW-1:0] reg_now;
    if (!rst_ni) begin
      last_code = '0;
      cw_count = '0;
      ccw_count = '0;
      ticks = '0;
      switch_up = 1'b1;
      regs = '{large_step: LargeStepRst, medium_step: MediumStepRst,
               small_step: SmallStepRst, fast_threshold: FastThresholdRst,
               slow_threshold: SlowThresholdRst};
      predicted_results.delete();
      fails = 0;
      checks = 0;
      steps_seen = 0;
      releases_seen = 0;
    end else begin
      // register port transfer
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[AddrW-1:2])
            REG_LARGE_STEP:     regs.large_step     = pwdata[7:0];
            REG_MEDIUM_STEP:    regs.medium_step    = pwdata[7:0];
            REG_SMALL_STEP:     regs.small_step     = pwdata[7:0];
            REG_FAST_THRESHOLD: regs.fast_threshold = pwdata[15:0];
            REG_SLOW_THRESHOLD: regs.slow_threshold = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (paddr[AddrW-1:2])
            REG_LARGE_STEP:     reg_now = DataW'(regs.large_step);
            REG_MEDIUM_STEP:    reg_now = DataW'(regs.medium_step);
            REG_SMALL_STEP:     reg_now = DataW'(regs.small_step);
            REG_FAST_THRESHOLD: reg_now = DataW'(regs.fast_threshold);
            REG_SLOW_THRESHOLD: reg_now = DataW'(regs.slow_threshold);
            default:            reg_now = prdata;
          endcase
          if (prdata !== reg_now) begin
            report("register read", reg_now, prdata);
          end
        end
      end
      // item transfer in: queue its expected result
      if (in_valid_i && in_ready_i) begin
        predicted_results.push_back(decode_item(in_data_i));
      end
      // result transfer out: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, got move %0d step %0d request %0d",
                   $time, out_data_i.move, out_data_i.step, out_data_i.reset_request);
        end else begin
          want = predicted_results.pop_front();
          checks++;
          if (want.move != MOVE_NONE) begin
            steps_seen++;
          end
          if (want.reset_request) begin
            releases_seen++;
          end
          if (out_data_i.move !== want.move) begin
            report("move", 32'(want.move), 32'(out_data_i.move));
          end
          if (out_data_i.step !== want.step) begin
            report("step", 32'(want.step), 32'(out_data_i.step));
          end
          if (out_data_i.reset_request !== want.reset_request) begin
            report("reset_request", 32'(want.reset_request), 32'(out_data_i.reset_request));
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_results.size();
    checked_o    <= checks;
    moves_o      <= steps_seen;
    releases_o   <= releases_seen;
  end

endmodule

// File: tb/sv/testbench.sv
// testbench: clock, reset, stimulus and verdict for quadrature_encoder_accel_decoder
// depends on qead_pkg, qead_stream_if, the block itself and qead_scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qead_pkg::*;

  localparam int unsigned ElapsedBits = 16;
  localparam int unsigned MaxGap      = 13;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned RegSlots    = 1 << $bits(reg_idx_e);

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic             pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;

  qead_stream_if #(.data_t(in_item_t))  in_ch ();
  qead_stream_if #(.data_t(out_item_t)) out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned moves;
  int unsigned releases;

  // shared knobs of the two sides
  bit          idle_on;
  bit          hold_req;
  // encoder position as last sent
  logic [1:0]  enc_code;
  logic        btn_level;
  bit          spin_ccw;
  int unsigned items_sent;

  quadrature_encoder_accel_decoder #(
    .ELAPSED_BITS(ElapsedBits)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qead_scoreboard #(
    .ELAPSED_BITS(ElapsedBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .moves_o      (moves),
    .releases_o   (releases)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // next gray code one detent along the chosen direction
  function automatic logic [1:0] gray_step(input logic [1:0] code, input bit ccw);
    logic [1:0] pos;
    pos = {code[1], code[1] ^ code[0]};
    pos = ccw ? pos - 2'd1 : pos + 2'd1;
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  // offer one item, after a random gap while idle_on is set, and wait for its transfer
  task automatic drive_item(input in_item_t item);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_pin(input logic [1:0] code, input logic btn);
    in_item_t item;
    item.mode    = MODE_PIN;
    item.phase_a = code[0];
    item.phase_b = code[1];
    item.button  = btn;
    enc_code  = code;
    btn_level = btn;
    drive_item(item);
  endtask

  // ticks carry random pin bits, which the block must ignore
  task automatic send_ticks(input int unsigned n);
    in_item_t item;
    item.mode = MODE_TICK;
    repeat (n) begin
      {item.phase_a, item.phase_b, item.button} = 3'($urandom);
      drive_item(item);
    end
  endtask

  task automatic turn(input int unsigned n);
    repeat (n) begin
      send_pin(gray_step(enc_code, spin_ccw), btn_level);
    end
  endtask

  // one register transfer: setup cycle, access cycle held until pready, then psel drops to idle
  task automatic reg_access(input bit wr, input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_all();
    for (int k = REG_LARGE_STEP; k <= REG_SLOW_THRESHOLD; k++) begin
      reg_access(1'b0, k[2:0], '0);
    end
  endtask

  // drop valid and wait until every expected result has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] l, input logic [7:0] m, input logic [7:0] s,
                            input logic [15:0] f, input logic [15:0] sl);
    wait_idle();
    reg_access(1'b1, REG_LARGE_STEP, DataW'(l));
    reg_access(1'b1, REG_MEDIUM_STEP, DataW'(m));
    reg_access(1'b1, REG_SMALL_STEP, DataW'(s));
    reg_access(1'b1, REG_FAST_THRESHOLD, DataW'(f));
    reg_access(1'b1, REG_SLOW_THRESHOLD, DataW'(sl));
    read_all();
  endtask

  // random traffic: mostly clean turning runs and tick bursts, some noise
  task automatic run_phase(input int unsigned n);
    int unsigned done_cnt;
    int unsigned kind;
    int unsigned len;
    logic [3:0]  bits;
    done_cnt = 0;
    while (done_cnt < n) begin
      if ($urandom_range(0, 5) == 0) begin
        idle_on = ~idle_on;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) begin
          spin_ccw = ~spin_ccw;
        end
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            btn_level = ~btn_level;
          end
          send_pin(gray_step(enc_code, spin_ccw), btn_level);
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 40);
        send_ticks(len);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          bits = 4'($urandom);
          if (bits[0]) begin
            send_ticks(1);
          end else begin
            send_pin(bits[2:1], bits[3]);
          end
        end
      end
      done_cnt += len;
    end
  endtask

  // result side: random stalls, or one long hold-off when asked
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end else begin
        stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    logic [7:0]  s_l;
    logic [7:0]  s_m;
    logic [7:0]  s_s;
    logic [15:0] t_f;
    logic [15:0] t_s;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    enc_code   = 2'd0;
    btn_level  = 1'b1;
    spin_ccw   = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: tick with pin bits high, then a press
    drive_item('{mode: MODE_TICK, phase_a: 1'b1, phase_b: 1'b1, button: 1'b1});
    send_pin(2'd0, 1'b1);
    send_pin(2'd0, 1'b0);
    // clockwise run, the release lands on the step-emitting detent
    spin_ccw = 1'b0;
    turn(3);
    send_pin(gray_step(enc_code, 1'b0), 1'b1);
    // counter-clockwise run
    spin_ccw = 1'b1;
    turn(4);
    // diagonal jumps there and back
    send_pin(2'd3, btn_level);
    send_pin(2'd0, btn_level);
    // reversal clears the other run
    spin_ccw = 1'b0;
    turn(1);
    spin_ccw = 1'b1;
    turn(1);
    // a tick with the switch down does not touch the switch level
    drive_item('{mode: MODE_TICK, phase_a: 1'b0, phase_b: 1'b0, button: 1'b0});
    send_pin(enc_code, 1'b1);

    // random phases over several settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          set_config(LargeStepRst, MediumStepRst, SmallStepRst, FastThresholdRst,
                     SlowThresholdRst);
        end
        1: begin
          set_config(8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
        end
        2: begin
          set_config(8'hFF, 8'd151, StepMax, 16'hFFFF, 16'hFFFF);
          // writes to unmapped slots must leave the registers alone
          for (int k = REG_SLOW_THRESHOLD + 1; k < RegSlots; k++) begin
            reg_access(1'b1, k[2:0], $urandom);
          end
          read_all();
        end
        3: begin
          set_config(StepMax, StepMin, 8'hFF, 16'd30, 16'd10);
        end
        4: begin
          set_config(8'd40, 8'd20, 8'd5, 16'd15, 16'd40);
          idle_on  = 1'b0;
          hold_req = 1'b1;
        end
        default: begin
          s_l = $urandom_range(0, 255);
          s_m = $urandom_range(0, 255);
          s_s = $urandom_range(0, 255);
          t_f = $urandom_range(0, 60);
          t_s = $urandom_range(0, 120);
          set_config(s_l, s_m, s_s, t_f, t_s);
        end
      endcase
      run_phase(PhaseItems);
    end

    wait_idle();
    $display("sent %0d items, checked %0d results: %0d steps and %0d switch releases",
             items_sent, checked, moves, releases);
    $display("swept %0d register settings incl. clamping and threshold order",
             NumPhases);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/qead_pkg.sv
src/qead_stream_if.sv
src/qead_apb_regs.sv
src/qead_core.sv
src/quadrature_encoder_accel_decoder.sv
src/qead_checker.sv
tb/sv/qead_checker.sv
tb/sv/testbench.sv
